FILE: src/lspg_pkg.sv
// Shared constants, codes and types for the LFSR position generator.
// No dependencies; every other file imports this package.
package lspg_pkg;

  localparam int LFSR_BITS      = 18;
  localparam int COORD_BITS     = 10;
  localparam int COUNT_BITS     = 16;
  localparam int SKIP_BITS      = 18;
  localparam int AREA_BITS      = 2 * COORD_BITS;
  localparam int DIV_BITS       = (LFSR_BITS > AREA_BITS) ? LFSR_BITS : AREA_BITS;
  localparam int STEP_BITS      = $clog2(COORD_BITS);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = LFSR_BITS;

  localparam logic [SKIP_BITS-1:0]  SKIP_MAX     = {SKIP_BITS{1'b1}};
  localparam logic [LFSR_BITS-1:0]  TAP_RESET    = LFSR_BITS'(2049);
  localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(400);
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(400);
  localparam logic [COUNT_BITS-1:0] TARGET_RESET = COUNT_BITS'(24000);
  localparam logic [AREA_BITS-1:0]  AREA_RESET   = AREA_BITS'(400 * 400);
  localparam logic [LFSR_BITS-1:0]  SEED_RESET   = LFSR_BITS'(1);

  typedef enum logic [2:0] {
    ST_RESTART  = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_POSITION = 3'd2,
    ST_WRAPPED  = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TAP_MASK     = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2,
    REG_TARGET_COUNT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [LFSR_BITS-1:0]  tap_mask;
    logic [COORD_BITS-1:0] image_width;
    logic [COORD_BITS-1:0] image_height;
    logic [COUNT_BITS-1:0] target_count;
    logic [AREA_BITS-1:0]  area;
  } cfg_t;

  // One classified step, handed from front to back.
  typedef struct packed {
    status_t               status;
    logic [LFSR_BITS-1:0]  value;
    logic [COUNT_BITS-1:0] position_index;
    logic [SKIP_BITS-1:0]  skipped_total;
    logic                  last;
  } pkt_t;

endpackage

FILE: src/lspg_cmd_if.sv
// Command channel: restart or advance requests into the generator.
// Depends on lspg_pkg.
interface lspg_cmd_if
  import lspg_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [LFSR_BITS-1:0] seed;

  modport source (output valid, cmd, seed, input ready);
  modport sink   (input valid, cmd, seed, output ready);
endinterface

FILE: src/lspg_pos_if.sv
// Result channel: one status/position record per command request.
// Depends on lspg_pkg.
interface lspg_pos_if
  import lspg_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [COORD_BITS-1:0] x_pos;
  logic [COORD_BITS-1:0] y_pos;
  logic [COUNT_BITS-1:0] position_index;
  logic [SKIP_BITS-1:0]  skipped_total;
  logic                  last;

  modport source (output valid, status, x_pos, y_pos, position_index, skipped_total, last,
                  input ready);
  modport sink   (input valid, status, x_pos, y_pos, position_index, skipped_total, last,
                  output ready);
endinterface

FILE: src/lspg_front.sv
// Front end: accepts command requests, steps the LFSR and classifies each value.
// Depends on lspg_pkg and lspg_cmd_if.
module lspg_front
  import lspg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  lspg_cmd_if.sink          cmd_ch,
  input  logic              full,
  output logic              push,
  output pkt_t              pkt
);

  logic [LFSR_BITS-1:0]  shift_state, shift_state_next;
  logic [LFSR_BITS-1:0]  start_value, start_value_next;
  logic [COUNT_BITS-1:0] emitted_count, emitted_count_next;
  logic [SKIP_BITS-1:0]  skip_count, skip_count_next;
  logic                  finished, finished_next;

  logic [LFSR_BITS-1:0]  stepped;
  logic [COUNT_BITS-1:0] emitted_inc;
  logic [SKIP_BITS-1:0]  skip_inc;

  assign cmd_ch.ready = !full;
  assign push         = cmd_ch.valid && !full;

  assign stepped     = {^(shift_state & cfg.tap_mask), shift_state[LFSR_BITS-1:1]};
  assign emitted_inc = emitted_count + COUNT_BITS'(1);
  assign skip_inc    = (skip_count == SKIP_MAX) ? skip_count : skip_count + SKIP_BITS'(1);

  always_comb begin
    shift_state_next   = shift_state;
    start_value_next   = start_value;
    emitted_count_next = emitted_count;
    skip_count_next    = skip_count;
    finished_next      = finished;
    pkt                = '0;
    pkt.position_index = emitted_count;
    pkt.skipped_total  = skip_count;
    if (cmd_ch.cmd) begin
      shift_state_next   = cmd_ch.seed;
      start_value_next   = cmd_ch.seed;
      emitted_count_next = '0;
      skip_count_next    = '0;
      finished_next      = 1'b0;
      pkt                = '0;
      pkt.status         = ST_RESTART;
    end else if (finished) begin
      pkt.status = ST_FINISHED;
    end else begin
      shift_state_next = stepped;
      if (stepped == start_value) begin
        finished_next = 1'b1;
        pkt.status    = ST_WRAPPED;
      end else if (DIV_BITS'(stepped) >= DIV_BITS'(cfg.area)) begin
        skip_count_next   = skip_inc;
        pkt.status        = ST_SKIPPED;
        pkt.skipped_total = skip_inc;
      end else begin
        emitted_count_next = emitted_inc;
        pkt.status         = ST_POSITION;
        pkt.value          = stepped;
        if (emitted_inc >= cfg.target_count || emitted_inc == '0) begin
          pkt.last      = 1'b1;
          finished_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_state   <= SEED_RESET;
      start_value   <= SEED_RESET;
      emitted_count <= '0;
      skip_count    <= '0;
      finished      <= 1'b0;
    end else if (push) begin
      shift_state   <= shift_state_next;
      start_value   <= start_value_next;
      emitted_count <= emitted_count_next;
      skip_count    <= skip_count_next;
      finished      <= finished_next;
    end
  end

endmodule

FILE: src/lspg_queue.sv
// Short FIFO of classified steps between front and back.
// Depends on lspg_pkg.
module lspg_queue
  import lspg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  output logic full,
  input  logic pop,
  output pkt_t head,
  output logic empty
);

  pkt_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

FILE: src/lspg_back.sv
// Back end: splits positions into x/y with a bit-serial divider, holds the result.
// Depends on lspg_pkg and lspg_pos_if.
module lspg_back
  import lspg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [COORD_BITS-1:0] image_width,
  input  pkt_t              head,
  input  logic              empty,
  output logic              pop,
  lspg_pos_if.source        pos_ch
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_HOLD = 3'b100
  } bstate_t;

  bstate_t               state;
  pkt_t                  hold;
  logic [DIV_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]   dvs;
  logic [COORD_BITS-1:0] quo;
  logic [STEP_BITS-1:0]  step;
  logic                  fits;

  assign pop  = (state == B_IDLE) && !empty;
  assign fits = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            state <= (head.status == ST_POSITION) ? B_DIV : B_HOLD;
          end
        end
        B_DIV: begin
          if (step == '0) begin
            state <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (pos_ch.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Restoring division: quotient bits MSB first, divisor walks right.
  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head;
      quo  <= '0;
      step <= STEP_BITS'(COORD_BITS - 1);
      if (head.status == ST_POSITION) begin
        rem <= DIV_BITS'(head.value);
        dvs <= DIV_BITS'(image_width) << (COORD_BITS - 1);
      end else begin
        rem <= '0;
        dvs <= '0;
      end
    end else if (state == B_DIV) begin
      if (fits) begin
        rem <= rem - dvs;
      end
      quo  <= {quo[COORD_BITS-2:0], fits};
      dvs  <= dvs >> 1;
      step <= step - STEP_BITS'(1);
    end
  end

  assign pos_ch.valid          = (state == B_HOLD);
  assign pos_ch.status         = hold.status;
  assign pos_ch.x_pos          = rem[COORD_BITS-1:0];
  assign pos_ch.y_pos          = quo;
  assign pos_ch.position_index = hold.position_index;
  assign pos_ch.skipped_total  = hold.skipped_total;
  assign pos_ch.last           = hold.last;

`ifndef SYNTH
  a_rem_below_width: assert property (@(posedge clk) disable iff (rst)
    (pos_ch.valid && pos_ch.status == ST_POSITION) |-> (rem < DIV_BITS'(image_width)))
    else $error("remainder not below width at output");

  a_no_coord_off_position: assert property (@(posedge clk) disable iff (rst)
    (pos_ch.valid && pos_ch.status != ST_POSITION) |-> (pos_ch.x_pos == '0 && pos_ch.y_pos == '0))
    else $error("coordinates set on a non-position result");

  a_div_then_hold: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV && step == '0) |=> (state == B_HOLD))
    else $error("divider did not finish into hold");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == B_DIV || state == B_HOLD))
    else $error("popped entry not taken up");
`endif

endmodule

FILE: src/lfsr_scrambled_position_generator.sv
// Top level of the LFSR scrambled position generator.
// Depends on lspg_pkg, lspg_cmd_if, lspg_pos_if, lspg_front, lspg_queue, lspg_back.
//
// Usage:
//   cmd_ch  (valid/ready) carries requests: cmd=1 restarts from seed, cmd=0 advances
//           the 18-bit Fibonacci LFSR one step.
//   pos_ch  (valid/ready) returns exactly one record per request: status, x/y of an
//           in-range value (value mod / div image_width), position index, skip count
//           and the last flag.
//   wr_en/wr_index/wr_data write tap_mask, image_width, image_height, target_count
//           (indexes 0..3); write only while no request is in flight.
// Flow: a restart, skip, wrap or finished request is written into the queue, popped
//   into the back end's hold state and then raises pos_ch.valid; a position first
//   passes the back end's bit-serial divider, which forms COORD_BITS (10) quotient bits.
//   The back end pops the next entry only after the current record has left pos_ch,
//   so the divider and the receiver set the rate at which records leave.
// The front end classifies a request in the cycle it is accepted and parks it in a
//   2-entry queue, so it keeps taking requests while the back end divides or while
//   pos_ch is stalled; cmd_ch.ready drops only when the queue is full.
// Reset (rst, synchronous): LFSR and seed are 1, counts clear, registers take their
//   defaults (mask 2049, 400 x 400, target 24000), queue and output empty.
// A stalled receiver holds the record on pos_ch unchanged until it is taken.
module lfsr_scrambled_position_generator
  import lspg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  lspg_cmd_if.sink                  cmd_ch,
  lspg_pos_if.source                pos_ch,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data
);

  cfg_t cfg;
  logic push, pop, full, empty;
  pkt_t push_pkt, head;

  logic [COORD_BITS-1:0] wr_coord;
  assign wr_coord = wr_data[COORD_BITS-1:0];

  // Configuration registers; the area product is refreshed on a width or height
  // write so the range test never needs a multiplier in the request path.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_mask     <= TAP_RESET;
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
      cfg.target_count <= TARGET_RESET;
      cfg.area         <= AREA_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_TAP_MASK: begin
          cfg.tap_mask <= wr_data[LFSR_BITS-1:0];
        end
        REG_IMAGE_WIDTH: begin
          cfg.image_width <= wr_coord;
          cfg.area        <= AREA_BITS'(wr_coord) * AREA_BITS'(cfg.image_height);
        end
        REG_IMAGE_HEIGHT: begin
          cfg.image_height <= wr_coord;
          cfg.area         <= AREA_BITS'(cfg.image_width) * AREA_BITS'(wr_coord);
        end
        REG_TARGET_COUNT: begin
          cfg.target_count <= wr_data[COUNT_BITS-1:0];
        end
        default: begin
          cfg.tap_mask <= cfg.tap_mask;
        end
      endcase
    end
  end

  lspg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd_ch (cmd_ch),
    .full   (full),
    .push   (push),
    .pkt    (push_pkt)
  );

  lspg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  lspg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .image_width (cfg.image_width),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .pos_ch      (pos_ch)
  );

endmodule
